FILE: rtl/core/atrb_pkg.sv
// ----------------------------------------------------------------------------
// atrb_pkg
// Shared types and constants of the ant tour roulette builder.
// ----------------------------------------------------------------------------
`default_nettype none
package atrb_pkg;
  localparam int unsigned MaxCitiesDefault = 32;
  localparam logic [1:0] ACT_LOAD_PHER = 2'd0;
  localparam logic [1:0] ACT_LOAD_COST = 2'd1;
  localparam logic [1:0] ACT_STEP      = 2'd2;
  localparam logic [6:0] PctMax        = 7'd99;
  localparam logic [6:0] PctScale      = 7'd100;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;      // latch the fields of an accepted item
    logic load_pher;    // write pheromone entry
    logic load_cost;    // write reciprocal entry (from divider result)
    logic div_start;    // start reciprocal divider
    logic tour_start;   // begin a tour
    logic scan_clear;   // clear scan accumulators and index
    logic rd_issue;     // issue memory read for scan index
    logic sum_acc;      // accumulate weight into total
    logic sel_acc;      // roulette pass step
    logic fb_acc;       // fallback pass step
    logic commit;       // mark chosen city, update tour state
    logic emit_load;    // send load status
    logic emit_city;    // send city status
  } atrb_cmd_t;

  typedef struct packed {
    logic div_done;
    logic tour_active;
    logic scan_end;     // last index issued
    logic total_zero;
    logic found;        // pick made in current pass
  } atrb_sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/ant_tour_roulette_builder.sv
// ----------------------------------------------------------------------------
// ant_tour_roulette_builder
// Ant-colony tour construction with percent roulette over matrix weights.
// ----------------------------------------------------------------------------
// Results: a pheromone load writes from a wait state, a cost load waits for
// the divider (one quotient bit a cycle), tour start and an unknown action
// answer from idle, and a tour step scans the matrix row over the clamped city count twice through one read port.
// One item at a time; busy drops in the cycle its result is strobed.
// Synchronous reset clears tour state and sets n_cities to 2; matrices are
// undefined until loaded. The receiver cannot stall results.
`default_nettype none
module ant_tour_roulette_builder #(
  parameter int unsigned MAX_CITIES = atrb_pkg::MaxCitiesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [4:0]  row,
  input  wire logic [4:0]  col,
  input  wire logic [15:0] value,
  input  wire logic [6:0]  percent_draw,
  input  wire logic [4:0]  index_draw,
  output logic             strobe,
  output logic             status,
  output logic [4:0]       city,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import atrb_pkg::*;

  atrb_cmd_t  cmd;
  atrb_sts_t  sts;
  logic [5:0] n_cities;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) n_cities <= 6'd2;
    else if (psel && penable && pwrite && paddr == 2'd0 && !sts.tour_active)
      n_cities <= pwdata[5:0];
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {26'd0, n_cities} : 32'd0;

  atrb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  atrb_datapath #(.MAX_CITIES(MAX_CITIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .action(action), .row(row), .col(col), .value(value),
    .percent_draw(percent_draw), .index_draw(index_draw),
    .n_cities(n_cities), .status(status), .city(city),
    .last(last), .strobe(strobe)
  );
endmodule
`default_nettype wire

FILE: rtl/core/atrb_datapath.sv
// ----------------------------------------------------------------------------
// atrb_datapath
// Matrix memories, reciprocal divider, weight multiplier and scan registers.
// ----------------------------------------------------------------------------
`default_nettype none
module atrb_datapath #(
  parameter int unsigned MAX_CITIES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire atrb_pkg::atrb_cmd_t  cmd,
  output atrb_pkg::atrb_sts_t       sts,
  input  wire logic [1:0]           action,
  input  wire logic [4:0]           row,
  input  wire logic [4:0]           col,
  input  wire logic [15:0]          value,
  input  wire logic [6:0]           percent_draw,
  input  wire logic [4:0]           index_draw,
  input  wire logic [5:0]           n_cities,
  output logic                      status,
  output logic [4:0]                city,
  output logic                      last,
  output logic                      strobe
);
  import atrb_pkg::*;

  localparam int unsigned IW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int unsigned AW = 2 * IW;
  localparam int unsigned DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int unsigned CW = IW + 1;

  // captured item fields
  logic [4:0]  row_q, col_q;
  logic [15:0] value_q;
  logic [6:0]  pct_q;
  logic [4:0]  idx_q;
  logic        oob_q;

  logic [15:0] pher_mem [DEPTH];
  logic [15:0] recip_mem [DEPTH];
  logic [15:0] pher_rd, recip_rd;

  // tour state
  logic [MAX_CITIES-1:0] visited;
  logic [IW-1:0]         cur;
  logic [CW-1:0]         remaining;
  logic                  active;
  logic [CW-1:0]         ncnt;

  // scan state
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] pipe_idx;
  logic          pipe_vld;
  logic [IW-1:0] pick;
  logic [IW-1:0] last_nz;
  logic          found;
  logic [37:0]   total;
  logic [37:0]   cum;
  logic [CW-1:0] seen;
  logic [31:0]   w_q;
  logic [IW-1:0] w_idx;
  logic          w_vld;

  // divider
  logic [16:0] div_rem;
  logic [15:0] div_quo;
  logic [4:0]  div_cnt;
  logic        div_busy, div_done;

  // clamp city count
  always_comb begin
    if (n_cities < 6'd2) ncnt = CW'(2);
    else if (32'(n_cities) > MAX_CITIES) ncnt = CW'(MAX_CITIES);
    else ncnt = CW'(n_cities);
  end

  // capture fields when an item arrives
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_q   <= row;
      col_q   <= col;
      value_q <= value;
      pct_q   <= (percent_draw > PctMax) ? PctMax : percent_draw;
      idx_q   <= index_draw;
      oob_q   <= (32'(row) >= MAX_CITIES) || (32'(col) >= MAX_CITIES);
    end
  end

  // restoring divider: 32768 / value, one quotient bit a cycle
  logic [16:0] div_trial;
  assign div_trial = {div_rem[15:0], (div_cnt == 5'd16)} - {1'b0, value_q};
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= 5'd16;
        div_rem  <= 17'd0;
        div_quo  <= 16'd0;
      end else if (div_busy) begin
        // shift in the dividend 0x8000: a single one bit on the first step
        if (!div_trial[16]) begin
          div_rem <= div_trial;
          div_quo <= {div_quo[14:0], 1'b1};
        end else begin
          div_rem <= {div_rem[15:0], (div_cnt == 5'd16)};
          div_quo <= {div_quo[14:0], 1'b0};
        end
        div_cnt <= div_cnt - 5'd1;
        if (div_cnt == 5'd1) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_addr = {row_q[IW-1:0], col_q[IW-1:0]};
  assign rd_addr = {cur, scan_idx};

  // matrix memories
  always_ff @(posedge clk) begin
    if (cmd.load_pher && !oob_q) pher_mem[wr_addr] <= value_q;
    if (cmd.load_cost && !oob_q)
      recip_mem[wr_addr] <= (value_q == 16'd0) ? 16'd0 : div_quo;
    pher_rd  <= pher_mem[rd_addr];
    recip_rd <= recip_mem[rd_addr];
  end

  // read pipeline, then registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
      w_vld    <= 1'b0;
    end else begin
      pipe_vld <= cmd.rd_issue;
      w_vld    <= pipe_vld;
    end
    pipe_idx <= scan_idx;
    w_q      <= pher_rd * recip_rd;
    w_idx    <= pipe_idx;
  end

  logic w_live;
  assign w_live = w_vld && !visited[w_idx];
  logic [44:0] lhs, rhs;
  assign lhs = 45'(pct_q) * 45'(total);
  assign rhs = 45'(PctScale) * 45'(cum + 38'(w_q));

  // scan index and accumulators
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_idx <= '0;
      cum      <= '0;
      seen     <= '0;
      found    <= 1'b0;
      last_nz  <= '0;
      if (cmd.sum_acc) total <= '0;
    end else begin
      if (cmd.rd_issue) scan_idx <= scan_idx + IW'(1);
      if (cmd.sum_acc && w_live) total <= total + 38'(w_q);
      if (cmd.sel_acc && w_live && !found) begin
        if (w_q != 32'd0) begin
          last_nz <= w_idx;
          if (lhs < rhs) begin
            found <= 1'b1;
            pick  <= w_idx;
          end
        end
        cum <= cum + 38'(w_q);
      end
      if (cmd.fb_acc && w_vld && !visited[w_idx] && !found) begin
        if (seen == ((CW'(idx_q) > remaining - CW'(1)) ? remaining - CW'(1) : CW'(idx_q)))
        begin
          found <= 1'b1;
          pick  <= w_idx;
        end
        seen <= seen + CW'(1);
      end
    end
  end

  // tour state and output
  always_ff @(posedge clk) begin
    if (rst) begin
      visited   <= '0;
      cur       <= '0;
      remaining <= '0;
      active    <= 1'b0;
      strobe    <= 1'b0;
      status    <= 1'b0;
      city      <= '0;
      last      <= 1'b0;
    end else begin
      strobe <= cmd.emit_load || cmd.emit_city;
      status <= cmd.emit_city;
      city   <= '0;
      last   <= 1'b0;
      if (cmd.tour_start) begin
        visited    <= MAX_CITIES'(1);
        cur        <= '0;
        remaining  <= ncnt - CW'(1);
        active     <= 1'b1;
      end else if (cmd.commit) begin
        visited[found ? pick : last_nz] <= 1'b1;
        cur <= found ? pick : last_nz;
        city <= 5'(found ? pick : last_nz);
        if (remaining <= CW'(1)) begin
          last      <= 1'b1;
          active    <= 1'b0;
          remaining <= '0;
        end else begin
          remaining <= remaining - CW'(1);
        end
      end
    end
  end

  // action is decoded in the controller
  logic unused_ok;
  assign unused_ok = ^action;

  assign sts.div_done    = div_done;
  assign sts.tour_active = active;
  assign sts.scan_end    = (32'(scan_idx) == 32'(ncnt) - 1) && cmd.rd_issue;
  assign sts.total_zero  = (total == '0) || unused_ok && 1'b0;
  assign sts.found       = found;
endmodule
`default_nettype wire

FILE: rtl/core/atrb_ctrl.sv
// ----------------------------------------------------------------------------
// atrb_ctrl
// Sequencer: loads, tour start, sum pass, roulette or fallback pass, commit.
// ----------------------------------------------------------------------------
`default_nettype none
module atrb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          action,
  input  wire atrb_pkg::atrb_sts_t sts,
  output atrb_pkg::atrb_cmd_t      cmd,
  output logic                     busy
);
  import atrb_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DIV   = 11'b00000000010,
    S_SUM   = 11'b00000000100,
    S_SDRN  = 11'b00000001000,
    S_SEL0  = 11'b00000010000,
    S_SEL   = 11'b00000100000,
    S_SELD  = 11'b00001000000,
    S_COMM  = 11'b00010000000,
    S_WAIT1 = 11'b00100000000,
    S_WAIT2 = 11'b01000000000,
    S_WAIT3 = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic   fb, fb_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fb    <= 1'b0;
    end else begin
      state <= state_next;
      fb    <= fb_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    fb_next    = fb;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          priority if (action == ACT_LOAD_PHER) begin
            state_next = S_WAIT1;
          end else if (action == ACT_LOAD_COST) begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end else if (action == ACT_STEP) begin
            if (!sts.tour_active) begin
              cmd.tour_start = 1'b1;
              cmd.emit_city  = 1'b1;
            end else begin
              cmd.scan_clear = 1'b1;
              cmd.sum_acc    = 1'b1;
              state_next     = S_SUM;
            end
          end else begin
            cmd.emit_load = 1'b1;
          end
        end
      end
      S_WAIT1: begin
        cmd.load_pher = 1'b1;
        cmd.emit_load = 1'b1;
        state_next = S_IDLE;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.load_cost = 1'b1;
          cmd.emit_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SUM: begin
        cmd.rd_issue = 1'b1;
        cmd.sum_acc  = 1'b1;
        if (sts.scan_end) state_next = S_SDRN;
      end
      S_SDRN: begin
        cmd.sum_acc = 1'b1;
        state_next  = S_WAIT2;
      end
      S_WAIT2: begin
        cmd.sum_acc = 1'b1;
        state_next  = S_SEL0;
      end
      S_SEL0: begin
        cmd.scan_clear = 1'b1;
        fb_next    = sts.total_zero;
        state_next = S_SEL;
      end
      S_SEL: begin
        cmd.rd_issue = 1'b1;
        cmd.sel_acc  = !fb;
        cmd.fb_acc   = fb;
        if (sts.scan_end) state_next = S_SELD;
      end
      S_SELD: begin
        cmd.sel_acc = !fb;
        cmd.fb_acc  = fb;
        state_next  = S_WAIT3;
      end
      // drain the weight of the last scanned city
      S_WAIT3: begin
        cmd.sel_acc = !fb;
        cmd.fb_acc  = fb;
        state_next  = S_COMM;
      end
      S_COMM: begin
        cmd.sel_acc   = !fb;
        cmd.fb_acc    = fb;
        state_next    = S_IDLE;
        cmd.commit    = 1'b0;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_COMM) begin
      cmd.sel_acc = 1'b0;
      cmd.fb_acc  = 1'b0;
      cmd.commit  = 1'b1;
      cmd.emit_city = 1'b1;
    end
  end

  assign busy = (state != S_IDLE);
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ant tour roulette builder. The matrix corner
// used by tours is filled first, then directed items and random phases run
// against an in-bench tour predictor, under several city counts and idle
// patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import atrb_pkg::*;

  localparam int unsigned Cities = MaxCitiesDefault;
  localparam int unsigned FillCities = 8;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [1:0] REG_N_CITIES = 2'd0;

  typedef struct packed {
    logic       status;
    logic [4:0] city;
    logic       last;
  } tour_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = ACT_LOAD_PHER;
  logic [4:0]  row = '0;
  logic [4:0]  col = '0;
  logic [15:0] value = '0;
  logic [6:0]  percent_draw = '0;
  logic [4:0]  index_draw = '0;
  logic        strobe;
  logic        status;
  logic [4:0]  city;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = REG_N_CITIES;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [15:0]  pher_mem [Cities*Cities];
  logic [15:0]  recip_mem [Cities*Cities];
  logic [31:0]  visited;
  logic [4:0]   cur_city;
  logic [5:0]   remain;
  logic         in_tour;
  logic [5:0]   n_reg;

  tour_result_t expected_q [$];
  int unsigned  fail_count = 0;
  int unsigned  send_idle_pct = 0;

  ant_tour_roulette_builder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .row(row), .col(col), .value(value),
    .percent_draw(percent_draw), .index_draw(index_draw),
    .strobe(strobe), .status(status), .city(city), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned cities_in_use();
    int unsigned n;
    n = n_reg;
    if (n < 2) n = 2;
    if (n > Cities) n = Cities;
    return n;
  endfunction

  function automatic longint unsigned edge_weight(int unsigned from, int unsigned to);
    int unsigned idx;
    idx = from * Cities + to;
    return longint'(pher_mem[idx]) * longint'(recip_mem[idx]);
  endfunction

  // roulette pick, or positional pick when every weight is zero
  function automatic logic [4:0] choose_city(logic [6:0] pd, logic [4:0] id);
    int unsigned n;
    longint unsigned total, cum, w, r;
    int unsigned last_nz, pos, seen;
    n = cities_in_use();
    total = 0;
    cum = 0;
    last_nz = 0;
    seen = 0;
    for (int j = 0; j < n; j++)
      if (!visited[j]) total += edge_weight(cur_city, j);
    if (total != 0) begin
      r = (pd > PctMax) ? PctMax : pd;
      for (int j = 0; j < n; j++) begin
        if (visited[j]) continue;
        w = edge_weight(cur_city, j);
        if (w != 0) begin
          last_nz = j;
          if (r * total < PctScale * (cum + w)) return j[4:0];
        end
        cum += w;
      end
      return last_nz[4:0];
    end
    pos = id;
    if (remain > 0 && pos > remain - 1) pos = remain - 1;
    for (int j = 0; j < n; j++) begin
      if (visited[j]) continue;
      last_nz = j;
      if (seen == pos) return j[4:0];
      seen++;
    end
    return last_nz[4:0];
  endfunction

  // update predictor for one accepted item and queue its result
  task automatic predict_item(logic [1:0] a, logic [4:0] r, logic [4:0] c, logic [15:0] v,
                              logic [6:0] pd, logic [4:0] id);
    tour_result_t res;
    res = '0;
    if (a == ACT_LOAD_PHER) begin
      pher_mem[r * Cities + c] = v;
    end else if (a == ACT_LOAD_COST) begin
      recip_mem[r * Cities + c] = (v == 0) ? 16'd0 : 16'(32768 / v);
    end else if (a == ACT_STEP) begin
      res.status = 1'b1;
      if (!in_tour) begin
        visited = 32'd1;
        cur_city = '0;
        remain = 6'(cities_in_use() - 1);
        in_tour = 1'b1;
        res.city = '0;
      end else begin
        res.city = choose_city(pd, id);
        if (remain <= 1) begin
          res.last = 1'b1;
          in_tour = 1'b0;
          remain = '0;
        end else begin
          remain = remain - 1;
        end
        visited[res.city] = 1'b1;
        cur_city = res.city;
      end
    end
    expected_q = {expected_q, res};
  endtask

  // send one item, with random idle cycles ahead of it
  task automatic send_item(logic [1:0] a, logic [4:0] r, logic [4:0] c, logic [15:0] v,
                           logic [6:0] pd, logic [4:0] id);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    @(negedge clk);
    action = a;
    row = r;
    col = c;
    value = v;
    percent_draw = pd;
    index_draw = id;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_item(a, r, c, v, pd, id);
    @(negedge clk);
    start = 1'b0;
  endtask

  // hold until every queued result has come back
  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // write the city count once nothing is in flight
  task automatic cfg_write(logic [5:0] v);
    while (expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = REG_N_CITIES;
    pwdata = 32'(v);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (pready && !in_tour) n_reg = v;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // check each strobed result against the oldest expectation
  always @(posedge clk) begin
    tour_result_t exp_res;
    if (!rst && strobe) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d city %0d last %0d", status, city, last);
        fail_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, status);
          fail_count++;
        end
        if (city !== exp_res.city) begin
          $error("city: expected %0d, got %0d", exp_res.city, city);
          fail_count++;
        end
        if (last !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, last);
          fail_count++;
        end
      end
    end
  end

  // fill the matrix corner that tours read; city counts stay within it
  task automatic test_fill_matrices();
    logic [15:0] ph;
    for (int r = 0; r < FillCities; r++) begin
      for (int c = 0; c < FillCities; c++) begin
        ph = ((r % 4) == 3 || $urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        send_item(ACT_LOAD_PHER, 5'(r), 5'(c), ph, '0, '0);
        send_item(ACT_LOAD_COST, 5'(r), 5'(c),
                  ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)), '0, '0);
      end
    end
  endtask

  // field extremes, unknown action, draws past 99, fallback with saturation
  task automatic test_directed();
    cfg_write(6'd2);
    send_item(ACT_STEP, 5'd31, 5'd31, 16'hFFFF, 7'd127, 5'd31);
    send_item(ACT_STEP, '0, '0, '0, 7'd0, 5'd0);
    send_item(ACT_LOAD_PHER, 5'd31, 5'd31, 16'hFFFF, 7'd127, 5'd31);
    send_item(ACT_LOAD_COST, 5'd31, 5'd31, 16'd0, '0, '0);
    send_item(ACT_LOAD_COST, 5'd31, 5'd30, 16'd1, '0, '0);
    send_item(ACT_LOAD_COST, 5'd31, 5'd29, 16'hFFFF, '0, '0);
    send_item(ACT_NONE, 5'd31, 5'd31, 16'hFFFF, 7'd127, 5'd31);
    drain();
    cfg_write(6'd4);
    // zero weights out of city 0
    for (int c = 1; c < 4; c++) send_item(ACT_LOAD_PHER, 5'd0, 5'(c), 16'd0, '0, '0);
    send_item(ACT_STEP, '0, '0, '0, 7'd0, 5'd0);
    send_item(ACT_STEP, '0, '0, '0, 7'd50, 5'd31);
    send_item(ACT_STEP, '0, '0, '0, 7'd100, 5'd0);
    send_item(ACT_STEP, '0, '0, '0, 7'd99, 5'd0);
    drain();
    cfg_write(6'(FillCities));
    send_item(ACT_STEP, '0, '0, '0, 7'd99, 5'd0);
    // write attempt during a tour is ignored
    cfg_write(6'd3);
    send_item(ACT_STEP, '0, '0, '0, 7'd127, 5'd31);
    send_item(ACT_STEP, '0, '0, '0, 7'd0, 5'd31);
  endtask

  task automatic random_item();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 70)
      send_item(ACT_STEP, 5'($urandom), 5'($urandom), 16'($urandom),
                ($urandom_range(9) == 0) ? 7'($urandom_range(100, 127)) : 7'($urandom_range(99)),
                5'($urandom));
    else if (k < 95)
      send_item(k < 83 ? ACT_LOAD_PHER : ACT_LOAD_COST, 5'($urandom), 5'($urandom),
                ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom), 7'($urandom), 5'($urandom));
    else
      send_item(ACT_NONE, 5'($urandom), 5'($urandom), 16'($urandom), 7'($urandom),
                5'($urandom));
  endtask

  task automatic test_random_phase(logic [5:0] n, int unsigned idle_pct, int unsigned count);
    drain();
    cfg_write(n);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      random_item();
      // pause until everything is back once mid-phase
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    for (int i = 0; i < Cities * Cities; i++) begin
      pher_mem[i] = '0;
      recip_mem[i] = '0;
    end
    visited = '0;
    cur_city = '0;
    remain = '0;
    in_tour = 1'b0;
    n_reg = 6'd2;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill_matrices();
    test_directed();
    test_random_phase(6'd5, 29, 70);
    test_random_phase(6'(FillCities), 29, 70);
    test_random_phase(6'd0, 72, 50);
    test_random_phase(6'd7, 72, 70);
    test_random_phase(6'd1, 0, 50);
    test_random_phase(6'($urandom_range(2, FillCities)), 0, 60);
    test_random_phase(6'd2, 0, 40);

    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
